>>> rtl/scpa_pkg.sv
package scpa_pkg;

	// Default geometry of the pools.
	localparam int BLOCKS_PER_POOL_DEF = 64;
	localparam int NUM_CLASSES_DEF     = 13;
	localparam int MIN_CLASS_SHIFT_DEF = 6;

	// Fixed field widths of the request and response.
	localparam int REQ_SIZE_W   = 20;
	localparam int HANDLE_W     = 10;
	localparam int CLASS_W      = 4;
	localparam int STATUS_W     = 3;
	localparam int MAX_SIZE_W   = 18;
	localparam int SIZE_CLS_W   = 5;

	localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 18'h3FFFF;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_TOO_LARGE  = 3'd1,
		ST_NO_BLOCK   = 3'd2,
		ST_BAD_HANDLE = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} ctl_cmd_t;

endpackage

>>> rtl/scpa_ctrl.sv
module scpa_ctrl import scpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A request is taken whenever the datapath is not in its execute cycle.
	assign busy   = (state_q == S_EXEC);
	assign done   = (state_q == S_RESP);
	assign accept = start && !busy;

	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == S_EXEC);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = accept ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// Every execute cycle is followed by exactly one response strobe.
	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute cycle not followed by a response");

	// A response only ever comes out of an execute cycle.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response without a preceding execute cycle");
`endif

endmodule

>>> rtl/scpa_dp.sv
module scpa_dp import scpa_pkg::*; #(
	parameter int BLOCKS_PER_POOL = BLOCKS_PER_POOL_DEF,
	parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
	parameter int MIN_CLASS_SHIFT = MIN_CLASS_SHIFT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	input  logic                  op,
	input  logic [REQ_SIZE_W-1:0] request_size,
	input  logic [HANDLE_W-1:0]   block_handle,
	input  logic                  cfg_we,
	input  logic [MAX_SIZE_W-1:0] cfg_wdata,
	output logic                  granted,
	output logic [HANDLE_W-1:0]   granted_handle,
	output logic [CLASS_W-1:0]    granted_class,
	output logic [STATUS_W-1:0]   status
);

	localparam int SLOT_W = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
	localparam int CNT_W  = $clog2(BLOCKS_PER_POOL + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int DEPTH  = NUM_CLASSES * BLOCKS_PER_POOL;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HEXT_W = 15;

	// Captured request and configuration.
	logic                  op_q;
	logic [REQ_SIZE_W-1:0] size_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [MAX_SIZE_W-1:0] max_size_q;

	// Per-class list state. fill_q counts entries rewritten since reset; since
	// frees write in ring order from entry zero, an entry below the fill mark
	// holds stored data and any other entry still holds its own index.
	logic [SLOT_W-1:0] head_q [NUM_CLASSES];
	logic [CNT_W-1:0]  cnt_q  [NUM_CLASSES];
	logic [CNT_W-1:0]  fill_q [NUM_CLASSES];

	logic [SLOT_W-1:0] mem [DEPTH];
	logic [SLOT_W-1:0] mem_rdata_q;

	// Response registers.
	logic                granted_q;
	status_t             status_q;
	logic [CLASS_W-1:0]  class_q;
	logic [HANDLE_W-1:0] base_q;
	logic                alloc_ok_q;
	logic                from_mem_q;
	logic [SLOT_W-1:0]   head_slot_q;

	// Decode signals.
	logic [REQ_SIZE_W-1:0] shifted;
	logic [SIZE_CLS_W-1:0] sz_cls;
	logic                  too_large;
	logic                  found;
	logic [CLS_W-1:0]      alloc_cls;
	logic [HEXT_W-1:0]     handle_ext;
	logic [HEXT_W-1:0]     free_base;
	logic [CLS_W-1:0]      free_cls;
	logic                  free_bad;
	logic [SLOT_W-1:0]     free_slot;
	logic [CLS_W-1:0]      sel_cls;
	logic [SLOT_W-1:0]     head_sel;
	logic [CNT_W-1:0]      cnt_sel;
	logic [CNT_W-1:0]      fill_sel;
	logic [SUM_W-1:0]      tail_sum;
	logic [SLOT_W-1:0]     tail;
	logic [SLOT_W-1:0]     head_next;
	logic [ADDR_W-1:0]     base_addr;
	logic [ADDR_W-1:0]     mem_addr;
	logic                  mem_we;
	logic                  mem_re;
	status_t               status_d;
	logic [SLOT_W-1:0]     out_slot;

	// Capture the request and take configuration writes.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			size_q   <= request_size;
			handle_q <= block_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= MAX_SIZE_RESET;
		end else if (cfg_we) begin
			max_size_q <= cfg_wdata;
		end
	end

	// Size class: bit length of the size after dropping the minimum block bits.
	always_comb begin
		shifted = size_q >> MIN_CLASS_SHIFT;
		sz_cls  = '0;
		for (int i = 0; i < REQ_SIZE_W; i++) begin
			if (shifted[i]) sz_cls = SIZE_CLS_W'(i + 1);
		end
		too_large = (size_q > REQ_SIZE_W'(max_size_q)) ||
			(sz_cls >= SIZE_CLS_W'(NUM_CLASSES));
	end

	// First non-empty class at or above the requested one.
	always_comb begin
		found     = 1'b0;
		alloc_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if ((cnt_q[c] != '0) && (SIZE_CLS_W'(c) >= sz_cls)) begin
				found     = 1'b1;
				alloc_cls = CLS_W'(c);
			end
		end
	end

	// Split a freed handle into class and slot against constant pool bounds.
	always_comb begin
		handle_ext = HEXT_W'(handle_q);
		free_cls   = '0;
		free_base  = '0;
		for (int k = 1; k < NUM_CLASSES; k++) begin
			if (handle_ext >= HEXT_W'(k * BLOCKS_PER_POOL)) begin
				free_cls  = CLS_W'(k);
				free_base = HEXT_W'(k * BLOCKS_PER_POOL);
			end
		end
		free_bad  = handle_ext >= HEXT_W'(NUM_CLASSES * BLOCKS_PER_POOL);
		free_slot = SLOT_W'(handle_ext - free_base);
	end

	// Read the chosen class's list pointers and form the ring positions.
	always_comb begin
		sel_cls   = (op_q == OP_ALLOC) ? alloc_cls : free_cls;
		head_sel  = head_q[sel_cls];
		cnt_sel   = cnt_q[sel_cls];
		fill_sel  = fill_q[sel_cls];
		tail_sum  = SUM_W'(head_sel) + SUM_W'(cnt_sel);
		if (tail_sum >= SUM_W'(BLOCKS_PER_POOL)) begin
			tail = SLOT_W'(tail_sum - SUM_W'(BLOCKS_PER_POOL));
		end else begin
			tail = SLOT_W'(tail_sum);
		end
		head_next = (head_sel == SLOT_W'(BLOCKS_PER_POOL - 1)) ? '0 : head_sel + 1'b1;
		base_addr = ADDR_W'(sel_cls) * ADDR_W'(BLOCKS_PER_POOL);
		mem_addr  = base_addr + ADDR_W'((op_q == OP_ALLOC) ? head_sel : tail);
	end

	// Outcome of the request.
	always_comb begin
		status_d = ST_OK;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (too_large) begin
				status_d = ST_TOO_LARGE;
			end else if (!found) begin
				status_d = ST_NO_BLOCK;
			end else begin
				mem_re = cmd.exec;
			end
		end else begin
			if (free_bad) begin
				status_d = ST_BAD_HANDLE;
			end else if (cnt_sel == CNT_W'(BLOCKS_PER_POOL)) begin
				status_d = ST_FULL;
			end else begin
				mem_we = cmd.exec;
			end
		end
	end

	// List pointer update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				cnt_q[c]  <= CNT_W'(BLOCKS_PER_POOL);
				fill_q[c] <= '0;
			end
		end else if (mem_re) begin
			head_q[sel_cls] <= head_next;
			cnt_q[sel_cls]  <= cnt_sel - 1'b1;
		end else if (mem_we) begin
			cnt_q[sel_cls] <= cnt_sel + 1'b1;
			if (fill_sel != CNT_W'(BLOCKS_PER_POOL)) begin
				fill_q[sel_cls] <= fill_sel + 1'b1;
			end
		end
	end

	// Free-slot memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= free_slot;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_addr];
		end
	end

	// Response registers, loaded in the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			granted_q   <= (status_d == ST_OK);
			status_q    <= status_d;
			class_q     <= (status_d == ST_OK) ? CLASS_W'(sel_cls) : '0;
			base_q      <= HANDLE_W'(base_addr);
			alloc_ok_q  <= mem_re;
			from_mem_q  <= CNT_W'(head_sel) < fill_sel;
			head_slot_q <= head_sel;
		end
	end

	// Response fields; an untouched entry still holds its own index.
	assign out_slot       = from_mem_q ? mem_rdata_q : head_slot_q;
	assign granted        = granted_q;
	assign granted_class  = class_q;
	assign status         = status_q;
	assign granted_handle = alloc_ok_q ? HANDLE_W'(base_q + HANDLE_W'(out_slot)) : '0;

`ifndef SYNTHESIS
	// Frees fill each ring in order, so a write lands on the fill mark.
	a_write_at_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (fill_sel == CNT_W'(BLOCKS_PER_POOL)) || (CNT_W'(tail) == fill_sel))
		else $error("free-list write out of ring order");

	// A memory read always produces a granted allocation on the next cycle.
	a_read_grants: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> alloc_ok_q && granted_q)
		else $error("memory read without a granted allocation");
`endif

endmodule

>>> rtl/size_class_pool_allocator.sv
// Block allocator with power-of-two size classes, each with a FIFO free list.
// Request channel: drive op, request_size and block_handle with start; the
// request is taken on a rising edge where start is high and busy is low.
// op selects allocate (pops the first non-empty class at or above the size's
// class) or free (appends the handle's slot to its class list).
// Response channel: done is high for exactly one cycle, in the response state
// after the execute state; granted, granted_handle, granted_class and status are
// valid in that cycle only. The receiver cannot stall; responses are never held.
// busy is high for the single execute cycle, in which the class lookup, pointer
// update and free-list memory access happen; a new request may be taken in the
// response cycle.
// Configuration: cfg_we with cfg_wdata writes the largest accepted request size;
// write it only while no request is in flight.
// Reset: asynchronous, active low. All lists come up full with slots in order
// and the size limit at its maximum; no clearing pass is needed, the block
// accepts requests as soon as reset is released.
module size_class_pool_allocator import scpa_pkg::*; #(
	parameter int BLOCKS_PER_POOL = BLOCKS_PER_POOL_DEF,
	parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
	parameter int MIN_CLASS_SHIFT = MIN_CLASS_SHIFT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  logic [REQ_SIZE_W-1:0] request_size,
	input  logic [HANDLE_W-1:0]   block_handle,
	input  logic                  cfg_we,
	input  logic [MAX_SIZE_W-1:0] cfg_wdata,
	output logic                  done,
	output logic                  granted,
	output logic [HANDLE_W-1:0]   granted_handle,
	output logic [CLASS_W-1:0]    granted_class,
	output logic [STATUS_W-1:0]   status
);

	ctl_cmd_t cmd;

	// Sequencing of each request.
	scpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Class lookup, list pointers and free-slot memory.
	scpa_dp #(
		.BLOCKS_PER_POOL (BLOCKS_PER_POOL),
		.NUM_CLASSES     (NUM_CLASSES),
		.MIN_CLASS_SHIFT (MIN_CLASS_SHIFT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.op             (op),
		.request_size   (request_size),
		.block_handle   (block_handle),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.granted        (granted),
		.granted_handle (granted_handle),
		.granted_class  (granted_class),
		.status         (status)
	);

endmodule
